// File: src/sipm_pkg.sv
// Shared types, constants and round function for the SipHash-2-4 MAC core.
// No dependencies; every other file of the block imports this package.
package sipm_pkg;

    localparam logic [63:0] SIP_C0        = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1        = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2        = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3        = 64'h7465646279746573;
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // Round engine phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ABS2 = 3'd1;
    localparam logic [2:0] PH_FIN1 = 3'd2;
    localparam logic [2:0] PH_FIN2 = 3'd3;
    localparam logic [2:0] PH_FIN3 = 3'd4;
    localparam logic [2:0] PH_FIN4 = 3'd5;

    typedef struct packed {
        logic [63:0] word;
        logic        is_final;
        logic        is_first;
    } sipm_entry_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } sipm_lanes_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               full;
        logic               empty;
    } sipm_fifo_stat_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       pop;
    } sipm_back_stat_t;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic sipm_lanes_t load_lanes(input logic [63:0] k0, input logic [63:0] k1);
        sipm_lanes_t l;
        l.a = SIP_C0 ^ k0;
        l.b = SIP_C1 ^ k1;
        l.c = SIP_C2 ^ k0;
        l.d = SIP_C3 ^ k1;
        return l;
    endfunction

    function automatic sipm_lanes_t sip_round(input sipm_lanes_t v);
        sipm_lanes_t r;
        logic [63:0] a1;
        logic [63:0] b1;
        logic [63:0] c1;
        logic [63:0] d1;
        a1 = v.a + v.b;
        b1 = rotl(v.b, 13) ^ a1;
        a1 = rotl(a1, 32);
        c1 = v.c + v.d;
        d1 = rotl(v.d, 16) ^ c1;
        a1 = a1 + d1;
        d1 = rotl(d1, 21) ^ a1;
        c1 = c1 + b1;
        b1 = rotl(b1, 17) ^ c1;
        c1 = rotl(c1, 32);
        r.a = a1;
        r.b = b1;
        r.c = c1;
        r.d = d1;
        return r;
    endfunction

endpackage

// File: src/siphash_2_4_mac_core.sv
// Top level of the SipHash-2-4 MAC core: key registers and the front end,
// queue and round engine. Depends on sipm_pkg, sipm_front, sipm_fifo, sipm_back.
//
// Usage. The key is written through the plain write port: cfg_index selects
// key_low (k0) or key_high (k1), and cfg_wdata is taken on every cycle with
// cfg_wr_en high. Write the key only while no message is in flight.
// Message words arrive on the s_ channel by valid/ready transfer, first byte
// in bits 7..0. Every word with s_final_word low absorbs all eight bytes.
// The last word of a message has s_final_word high and carries 0 to 7 bytes
// given by s_valid_bytes (larger counts act as 7); it yields one tag on the
// m_ channel. A message of whole words ends with an empty final word.
// The round engine does one SipRound per cycle while it holds a word, but waits at
// the last finalization round while a tag waits; it takes a new word from the
// queue only when it is done with the previous one.
// A two-entry queue sits between the front end and the round engine, so the
// sender keeps transferring until the queue is full while the engine works or a tag waits.
// If the receiver stalls, the tag holds in its output register and the
// engine stops at the last finalization round of the next message.
// Reset clears the key to zero, empties the queue and output, and starts a
// new message; lanes are loaded from the key at each message's first word.
module siphash_2_4_mac_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_message_word,
    input  logic [3:0]  s_valid_bytes,
    input  logic        s_final_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_tag
);
    import sipm_pkg::*;

    logic [63:0]     key_low_reg;
    logic [63:0]     key_low_next;
    logic [63:0]     key_high_reg;
    logic [63:0]     key_high_next;
    logic            q_push;
    sipm_entry_t     q_wr_entry;
    sipm_entry_t     q_rd_entry;
    sipm_fifo_stat_t q_stat;
    sipm_back_stat_t b_stat;

    // Key registers: a write lands on the selected half.
    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_next  = cfg_wdata;
                CFG_KEY_HIGH: key_high_next = cfg_wdata;
                default:      key_low_next  = key_low_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= 64'd0;
            key_high_reg <= 64'd0;
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    // The front end pads the final word and marks the first word of a message.
    sipm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_valid_bytes  (s_valid_bytes),
        .s_final_word   (s_final_word),
        .q_full         (q_stat.full),
        .q_push         (q_push),
        .q_entry        (q_wr_entry)
    );

    sipm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (b_stat.pop),
        .rd_entry (q_rd_entry),
        .stat     (q_stat)
    );

    // The round engine loads lanes from the key when a first word arrives.
    sipm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .q_empty  (q_stat.empty),
        .q_entry  (q_rd_entry),
        .stat     (b_stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_tag    (m_tag)
    );

    // A word taken from the queue always keeps the engine busy next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.pop |=> (b_stat.phase == PH_ABS2))
        else $error("round engine did not start after a queue pop");

    // A new tag only appears right after the last finalization round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> ($past(b_stat.phase) == PH_FIN4))
        else $error("tag raised outside the finalization phase");

    // The front end never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_stat.count != FIFO_CW'(FIFO_DEPTH)))
        else $error("push into a full queue");

    // The engine only pops while idle and the queue holds an entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.pop |-> (!q_stat.empty && (b_stat.phase == PH_IDLE)))
        else $error("pop while busy or from an empty queue");

endmodule

// File: src/sipm_front.sv
// Front end: accepts message words, tracks the message length and builds the
// padded final word. Depends on sipm_pkg.
module sipm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_message_word,
    input  logic [3:0]          s_valid_bytes,
    input  logic                s_final_word,
    input  logic                q_full,
    output logic                q_push,
    output sipm_pkg::sipm_entry_t q_entry
);
    import sipm_pkg::*;

    logic [7:0]  length_reg;
    logic [7:0]  length_next;
    logic        fresh_reg;
    logic        fresh_next;
    logic [2:0]  cnt;
    logic [7:0]  total;
    logic [63:0] masked;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        cnt = (s_valid_bytes > 4'd7) ? 3'd7 : s_valid_bytes[2:0];
        for (int i = 0; i < 8; i++) begin
            masked[8*i +: 8] = (3'(i) < cnt) ? s_message_word[8*i +: 8] : 8'h00;
        end
        // A message is fresh only until its first word, so the running length
        // starts from zero there.
        total = (fresh_reg ? 8'd0 : length_reg) + {5'b0, cnt};

        q_entry.is_first = fresh_reg;
        q_entry.is_final = s_final_word;
        q_entry.word     = s_final_word ? {total, masked[55:0]} : s_message_word;

        length_next = length_reg;
        fresh_next  = fresh_reg;
        if (q_push) begin
            if (s_final_word) begin
                length_next = 8'd0;
                fresh_next  = 1'b1;
            end else begin
                length_next = (fresh_reg ? 8'd0 : length_reg) + 8'd8;
                fresh_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= 8'd0;
            fresh_reg  <= 1'b1;
        end else begin
            length_reg <= length_next;
            fresh_reg  <= fresh_next;
        end
    end

endmodule

// File: src/sipm_fifo.sv
// Two-entry queue between the front end and the round engine.
// Depends on sipm_pkg for the entry type and depth.
module sipm_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  sipm_pkg::sipm_entry_t     wr_entry,
    input  logic                      pop,
    output sipm_pkg::sipm_entry_t     rd_entry,
    output sipm_pkg::sipm_fifo_stat_t stat
);
    import sipm_pkg::*;

    sipm_entry_t        mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_entry   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CW'(do_push) - FIFO_CW'(do_pop);
        end
    end

endmodule

// File: src/sipm_back.sv
// Round engine and tag output register: one SipRound per cycle over the four lanes
// while busy, held at the last finalization round while a tag waits. Depends on sipm_pkg.
module sipm_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [63:0]               key_low,
    input  logic [63:0]               key_high,
    input  logic                      q_empty,
    input  sipm_pkg::sipm_entry_t     q_entry,
    output sipm_pkg::sipm_back_stat_t stat,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [63:0]               m_tag
);
    import sipm_pkg::*;

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    sipm_lanes_t lanes_reg;
    sipm_lanes_t lanes_next;
    logic [63:0] msg_reg;
    logic [63:0] msg_next;
    logic        fin_reg;
    logic        fin_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [63:0] m_tag_reg;
    logic [63:0] m_tag_next;
    sipm_lanes_t start_lanes;
    sipm_lanes_t r_out;
    logic        pop;
    logic        out_free;

    assign pop       = (phase_reg == PH_IDLE) && !q_empty;
    assign out_free  = !m_valid_reg || m_ready;
    assign stat.phase = phase_reg;
    assign stat.pop   = pop;
    assign m_valid   = m_valid_reg;
    assign m_tag     = m_tag_reg;

    always_comb begin
        start_lanes   = q_entry.is_first ? load_lanes(key_low, key_high) : lanes_reg;
        start_lanes.d = start_lanes.d ^ q_entry.word;
        r_out = sip_round((phase_reg == PH_IDLE) ? start_lanes : lanes_reg);

        phase_next   = phase_reg;
        lanes_next   = lanes_reg;
        msg_next     = msg_reg;
        fin_next     = fin_reg;
        m_tag_next   = m_tag_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (phase_reg)
            PH_IDLE: begin
                if (pop) begin
                    lanes_next = r_out;
                    msg_next   = q_entry.word;
                    fin_next   = q_entry.is_final;
                    phase_next = PH_ABS2;
                end
            end
            PH_ABS2: begin
                lanes_next   = r_out;
                lanes_next.a = r_out.a ^ msg_reg;
                if (fin_reg) begin
                    lanes_next.c = r_out.c ^ SIP_FINAL_XOR;
                    phase_next   = PH_FIN1;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_FIN1, PH_FIN2, PH_FIN3: begin
                lanes_next = r_out;
                phase_next = phase_reg + 3'd1;
            end
            PH_FIN4: begin
                if (out_free) begin
                    m_tag_next   = r_out.a ^ r_out.b ^ r_out.c ^ r_out.d;
                    m_valid_next = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        msg_reg   <= msg_next;
        fin_reg   <= fin_next;
        m_tag_reg <= m_tag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
